[rtl/bcm_pkg.sv]
// shared constants, types and a function for the battery cell monitor
`timescale 1ns / 1ps

package bcm_pkg;

  localparam int SAMPLE_W = 15;
  localparam int COUNT_W  = 4;
  localparam int OFFSET_W = 12;
  localparam int THRESH_W = 13;
  localparam int TOTAL_W  = 17;
  localparam int WARN_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int MIN_CELLS_DEFAULT = 1;

  localparam int MV_PER_STEP    = 100;
  localparam int STEPS_PER_CELL = 42;
  localparam int DETECT_STEP    = MV_PER_STEP * STEPS_PER_CELL;
  localparam int DETECT_MAX     = (2 ** SAMPLE_W - 1) / DETECT_STEP;

  localparam int RECIP_SHIFT = 16;
  localparam int RECIP3      = ((2 ** RECIP_SHIFT) + 2) / 3;
  localparam int RECIP_W     = 15;
  localparam int THIRD_W     = 12;

  localparam int QUO_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [WARN_W-1:0]    warn_t;

  localparam cfg_idx_t REG_CELL_MODE    = 3'd0;
  localparam cfg_idx_t REG_MANUAL_COUNT = 3'd1;
  localparam cfg_idx_t REG_OFFSET       = 3'd2;
  localparam cfg_idx_t REG_LOW_CELL     = 3'd3;
  localparam cfg_idx_t REG_GRADUAL_TOP  = 3'd4;

  localparam warn_t WARN_NONE     = 3'd0;
  localparam warn_t WARN_SUBTLE   = 3'd1;
  localparam warn_t WARN_SLOW     = 3'd2;
  localparam warn_t WARN_RAPID    = 3'd3;
  localparam warn_t WARN_CRITICAL = 3'd4;

  // floor(v / 4200) + 1 by independent threshold compares
  function automatic logic [COUNT_W-1:0] detect_count(input logic [SAMPLE_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(1);
    for (int k = 1; k <= DETECT_MAX; k++) begin
      if ({1'b0, v} >= (SAMPLE_W + 1)'(k * DETECT_STEP)) begin
        n = COUNT_W'(k + 1);
      end
    end
    return n;
  endfunction

endpackage

[rtl/battery_cell_monitor.sv]
// battery cell monitor top level: state, sequencer and shared restoring divider
`timescale 1ns / 1ps

//  channel   signals                                           direction
//  in        in_valid, in_ready, command, sample_mv             input transaction
//  out       out_valid, out_ready, cells, total_mv,             output transaction
//            per_cell_mv, is_low, warn_level
//  cfg       cfg_wen, cfg_index, cfg_data                      register write
//
//  each transaction runs from accept through ST_PREP, which forms the total, ST_DIV,
//  which runs the shared subtract unit one quotient bit at a time, and ST_WARN, which
//  grades the per-cell voltage. in_ready is high only while idle, so a new transaction
//  is not accepted until the previous one has left ST_WARN.
//  the result sits in an output register, so a new transaction is taken while it waits;
//  a finished result waits in the grading step only while the register is still full.
//  rst is synchronous and restores register defaults and clears the stored state.

module battery_cell_monitor #(
  parameter int MIN_CELLS = bcm_pkg::MIN_CELLS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [bcm_pkg::SAMPLE_W-1:0]      sample_mv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bcm_pkg::COUNT_W-1:0]       cells,
  output logic signed [bcm_pkg::TOTAL_W-1:0] total_mv,
  output logic signed [bcm_pkg::TOTAL_W-1:0] per_cell_mv,
  output logic                              is_low,
  output logic [bcm_pkg::WARN_W-1:0]        warn_level,
  input  logic                              cfg_wen,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WARN = 2'd3;

  localparam int TW = bcm_pkg::TOTAL_W;
  localparam int QW = bcm_pkg::QUO_W;
  localparam int CW = bcm_pkg::COUNT_W;
  localparam int HW = bcm_pkg::THRESH_W;
  localparam int SW = $clog2(QW);

  logic [1:0] state;

  logic                          cell_mode;
  logic [CW-1:0]                 manual_cell_count;
  logic signed [bcm_pkg::OFFSET_W-1:0] offset_mv;
  logic [HW-1:0]                 low_cell_mv;
  logic [HW-1:0]                 gradual_top_mv;

  logic [bcm_pkg::SAMPLE_W-1:0]  stored_mv;
  logic [CW-1:0]                 cell_total;

  logic signed [TW-1:0]          total_r;
  logic                          neg;
  logic [QW-1:0]                 quo;
  logic [CW-1:0]                 rem;
  logic [SW-1:0]                 step;
  logic [bcm_pkg::THIRD_W-1:0]   third;

  logic [CW-1:0]                 detected;
  logic signed [TW-1:0]          sum;
  logic [TW-1:0]                 mag;
  logic [HW:0]                   span;
  logic [HW+bcm_pkg::RECIP_W-1:0] prod;
  logic [CW:0]                   rem_shift;
  logic [CW:0]                   rem_sub;
  logic                          take;
  logic [TW-1:0]                 quo_neg;
  logic signed [TW-1:0]          per_val;
  logic signed [TW:0]            per_x;
  logic [HW:0]                   bot_one;
  logic [HW:0]                   bot_two;
  logic                          low_flag;
  logic [bcm_pkg::WARN_W-1:0]    warn_val;
  logic                          out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    detected = bcm_pkg::detect_count(sample_mv);
    if (detected < CW'(MIN_CELLS)) begin
      detected = CW'(MIN_CELLS);
    end
  end

  // total and magnitude for the divider
  assign sum = $signed({2'b00, stored_mv}) +
               $signed({{(TW - bcm_pkg::OFFSET_W){offset_mv[bcm_pkg::OFFSET_W-1]}}, offset_mv});
  assign mag = sum[TW-1] ? TW'(-sum) : TW'(sum);

  // third of the gradual range by reciprocal multiply
  assign span = {1'b0, gradual_top_mv} - {1'b0, low_cell_mv};
  assign prod = span[HW-1:0] * bcm_pkg::RECIP_W'(bcm_pkg::RECIP3);

  // shared subtract unit
  assign rem_shift = {rem, quo[QW-1]};
  assign take      = rem_shift >= {1'b0, cell_total};
  assign rem_sub   = rem_shift - {1'b0, cell_total};

  always_comb begin
    quo_neg = TW'(-$signed({1'b0, quo}));
    if (cell_total == '0) begin
      per_val = total_r;
    end else if (neg) begin
      per_val = $signed(quo_neg);
    end else begin
      per_val = $signed({1'b0, quo});
    end
    per_x   = {per_val[TW-1], per_val};
    bot_one = {1'b0, low_cell_mv} + {2'b00, third[bcm_pkg::THIRD_W-1:0]};
    bot_two = bot_one + {2'b00, third};
    low_flag = (cell_total == '0) ||
               (per_x <= $signed({{(TW-HW){1'b0}}, low_cell_mv}));
    if (low_flag) begin
      warn_val = bcm_pkg::WARN_CRITICAL;
    end else if ((per_x > $signed({{(TW-HW){1'b0}}, gradual_top_mv})) ||
                 (gradual_top_mv <= low_cell_mv)) begin
      warn_val = bcm_pkg::WARN_NONE;
    end else if (per_x <= $signed({{(TW-HW-1){1'b0}}, bot_one})) begin
      warn_val = bcm_pkg::WARN_RAPID;
    end else if (per_x <= $signed({{(TW-HW-1){1'b0}}, bot_two})) begin
      warn_val = bcm_pkg::WARN_SLOW;
    end else begin
      warn_val = bcm_pkg::WARN_SUBTLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cell_mode         <= 1'b0;
      manual_cell_count <= '0;
      offset_mv         <= '0;
      low_cell_mv       <= HW'(3300);
      gradual_top_mv    <= HW'(3700);
      stored_mv         <= '0;
      cell_total        <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_WARN)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        unique case (cfg_index)
          bcm_pkg::REG_CELL_MODE:    cell_mode         <= cfg_data[0];
          bcm_pkg::REG_MANUAL_COUNT: manual_cell_count <= cfg_data[CW-1:0];
          bcm_pkg::REG_OFFSET:       offset_mv         <= $signed(cfg_data[bcm_pkg::OFFSET_W-1:0]);
          bcm_pkg::REG_LOW_CELL:     low_cell_mv       <= cfg_data[HW-1:0];
          bcm_pkg::REG_GRADUAL_TOP:  gradual_top_mv    <= cfg_data[HW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!command) begin
              stored_mv <= sample_mv;
            end else if (!cell_mode) begin
              cell_total        <= detected;
              manual_cell_count <= detected;
            end else begin
              cell_total <= manual_cell_count;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          total_r <= sum;
          neg     <= sum[TW-1];
          quo     <= mag[QW-1:0];
          rem     <= '0;
          step    <= '0;
          third   <= prod[bcm_pkg::RECIP_SHIFT +: bcm_pkg::THIRD_W];
          state   <= ST_DIV;
        end
        ST_DIV: begin
          quo  <= {quo[QW-2:0], take};
          rem  <= take ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
          step <= step + 1'b1;
          if (step == SW'(QW - 1)) begin
            state <= ST_WARN;
          end
        end
        ST_WARN: begin
          if (out_free) begin
            cells       <= cell_total;
            total_mv    <= total_r;
            per_cell_mv <= per_val;
            is_low      <= low_flag;
            warn_level  <= warn_val;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
